[hw/rtl/lennard_jones_pair_force_core_defines.svh]
// Assertion macros shared by the pair force core RTL.
`ifndef LENNARD_JONES_PAIR_FORCE_CORE_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LJPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ljpf same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LJPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ljpf next-cycle check failed");

`endif

[hw/rtl/ljpf_pkg.sv]
// Shared types, widths and constants of the pair force core.
package ljpf_pkg;

    localparam int ID_BITS    = 16;
    localparam int POS_W      = 24;
    localparam int CUT_W      = 32;
    localparam int OUT_W      = 32;
    localparam int SQ_W       = 2 * POS_W;
    localparam int R2_W       = SQ_W + 1;
    localparam int Q_W        = 64;
    localparam int QH_W       = Q_W / 2;
    localparam int FRAC_W     = 16;
    localparam int DIV_STEPS  = Q_W;
    localparam int REG_IDX_W  = 8;
    localparam int REG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_WELL_DEPTH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SIGMA_POW6 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF_SQ  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_INV_MASS   = REG_IDX_W'(3);

    localparam logic [POS_W-1:0] RST_WELL_DEPTH = POS_W'(327680);
    localparam logic [POS_W-1:0] RST_SIGMA_POW6 = POS_W'(65536);
    localparam logic [CUT_W-1:0] RST_CUTOFF_SQ  = CUT_W'(589824);
    localparam logic [POS_W-1:0] RST_INV_MASS   = POS_W'(65536);

    // Q32.32 magnitude with sticky overflow
    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] m;
    } t_qval;

    // fields that ride along the pipeline with each item
    typedef struct packed {
        logic             used;
        logic             r2_one;
        logic             xneg;
        logic             yneg;
        logic [POS_W-1:0] dxm;
        logic [POS_W-1:0] dym;
        t_qval            inv;
        t_qval            s6;
        logic             tneg;
        logic             eneg;
        t_qval            e;
    } t_side;

    typedef struct packed {
        logic             pair_used;
        logic [OUT_W-1:0] accel_x;
        logic [OUT_W-1:0] accel_y;
        logic [OUT_W-1:0] pair_energy;
        logic             clipped;
    } t_result;

    function automatic logic qzero(t_qval a);
        return !a.ovf && (a.m == '0);
    endfunction

endpackage

[hw/rtl/ljpf_if.sv]
// Handshake channels of the pair force core: pair in, result out, config write.
interface ljpf_pair_if;
    import ljpf_pkg::*;
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] first_id;
    logic [ID_BITS-1:0] second_id;
    logic [POS_W-1:0]   first_x;
    logic [POS_W-1:0]   first_y;
    logic [POS_W-1:0]   second_x;
    logic [POS_W-1:0]   second_y;
    modport source (output valid, first_id, second_id, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink (input valid, first_id, second_id, first_x, first_y, second_x, second_y,
                  output ready);
endinterface

interface ljpf_result_if;
    import ljpf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    pair_used;
    logic signed [OUT_W-1:0] accel_x;
    logic signed [OUT_W-1:0] accel_y;
    logic signed [OUT_W-1:0] pair_energy;
    logic                    clipped;
    modport source (output valid, pair_used, accel_x, accel_y, pair_energy, clipped,
                    input ready);
    modport sink (input valid, pair_used, accel_x, accel_y, pair_energy, clipped,
                  output ready);
endinterface

interface ljpf_cfg_if;
    import ljpf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [REG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/ljpf_recip.sv]
// Pipelined restoring divider: floor(2^64 / r2), one quotient bit per stage.
module ljpf_recip (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [ljpf_pkg::R2_W-1:0] i_r2,
    input  ljpf_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic [ljpf_pkg::Q_W-1:0] o_quot,
    output ljpf_pkg::t_side         o_side
);
    import ljpf_pkg::*;

    logic              r_v    [DIV_STEPS];
    logic [R2_W-1:0]   r_rem  [DIV_STEPS];
    logic [R2_W-1:0]   r_d    [DIV_STEPS];
    logic [Q_W-1:0]    r_q    [DIV_STEPS];
    t_side             r_side [DIV_STEPS];

    logic              w_v_in    [DIV_STEPS];
    logic [R2_W-1:0]   w_rem_in  [DIV_STEPS];
    logic [R2_W-1:0]   w_d_in    [DIV_STEPS];
    logic [Q_W-1:0]    w_q_in    [DIV_STEPS];
    t_side             w_side_in [DIV_STEPS];
    logic [R2_W:0]     w_sh      [DIV_STEPS];
    logic              w_ge      [DIV_STEPS];
    logic [R2_W-1:0]   n_rem     [DIV_STEPS];
    logic [Q_W-1:0]    n_q       [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            // dividend 2^64: top bit gives remainder 1, then shift in zeros
            assign w_v_in[k]    = i_valid;
            assign w_rem_in[k]  = R2_W'(1);
            assign w_d_in[k]    = i_r2;
            assign w_q_in[k]    = '0;
            assign w_side_in[k] = i_side;
        end else begin : g_next
            assign w_v_in[k]    = r_v[k-1];
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_d_in[k]    = r_d[k-1];
            assign w_q_in[k]    = r_q[k-1];
            assign w_side_in[k] = r_side[k-1];
        end

        assign w_sh[k]  = {w_rem_in[k], 1'b0};
        assign w_ge[k]  = w_sh[k] >= {1'b0, w_d_in[k]};
        assign n_rem[k] = w_ge[k] ? R2_W'(w_sh[k] - {1'b0, w_d_in[k]}) : w_sh[k][R2_W-1:0];
        assign n_q[k]   = {w_q_in[k][Q_W-2:0], w_ge[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_d[k]    <= w_d_in[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_q[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

[hw/rtl/ljpf_qmul.sv]
// Two-stage Q32.32 multiplier with overflow marks; partial products, then sum.
module ljpf_qmul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ljpf_pkg::t_qval i_a,
    input  ljpf_pkg::t_qval i_b,
    input  ljpf_pkg::t_side i_side,
    output logic            o_valid,
    output ljpf_pkg::t_qval o_r,
    output ljpf_pkg::t_side o_side
);
    import ljpf_pkg::*;

    logic             r_v1;
    logic             r_v2;
    logic             r_zero;
    logic             r_ovf;
    logic [Q_W-1:0]   r_ll;
    logic [Q_W-1:0]   r_lh;
    logic [Q_W-1:0]   r_hl;
    logic [Q_W-1:0]   r_hh;
    t_side            r_side1;
    t_side            r_side2;
    t_qval            r_r;
    logic [2*Q_W-1:0] w_full;
    t_qval            n_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero  <= qzero(i_a) || qzero(i_b);
            r_ovf   <= i_a.ovf || i_b.ovf;
            r_ll    <= i_a.m[QH_W-1:0] * i_b.m[QH_W-1:0];
            r_lh    <= i_a.m[QH_W-1:0] * i_b.m[Q_W-1:QH_W];
            r_hl    <= i_a.m[Q_W-1:QH_W] * i_b.m[QH_W-1:0];
            r_hh    <= i_a.m[Q_W-1:QH_W] * i_b.m[Q_W-1:QH_W];
            r_side1 <= i_side;
            r_r     <= n_r;
            r_side2 <= r_side1;
        end
    end

    assign w_full = {r_hh, r_ll} + {{QH_W{1'b0}}, r_lh, {QH_W{1'b0}}}
                  + {{QH_W{1'b0}}, r_hl, {QH_W{1'b0}}};

    always_comb begin
        n_r = '0;
        if (r_zero) begin
            n_r = '0;
        end else if (r_ovf || (w_full[2*Q_W-1:Q_W+QH_W] != '0)) begin
            n_r.ovf = 1'b1;
        end else begin
            n_r.m = w_full[Q_W+QH_W-1:QH_W];
        end
    end

    assign o_valid = r_v2;
    assign o_r     = r_r;
    assign o_side  = r_side2;

endmodule

[hw/rtl/lennard_jones_pair_force_core.sv]
// Top level of the Lennard-Jones 12-6 pair force core with cutoff.
// Pipeline of 88 register stages from pair accept to result valid: 4 front, 64
// divider stages for 1/r2, eight multiplier steps, 3 single stages, output reg.
// Throughput: one pair per cycle; the pipeline halts only when the output skid
// register is full. Sync active-low reset clears valid bits and loads register
// defaults; no clearing pass, the block is ready the cycle after reset.
`include "lennard_jones_pair_force_core_defines.svh"

module lennard_jones_pair_force_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ljpf_pair_if.sink            i_pair,
    ljpf_result_if.source        o_result,
    ljpf_cfg_if.sink             i_cfg
);
    import ljpf_pkg::*;

    localparam logic [4:0]       SCALE_TWO  = 5'd2;
    localparam logic [4:0]       SCALE_FOUR = 5'd4;
    localparam logic [4:0]       SCALE_LJ   = 5'd24;
    localparam logic [OUT_W-1:0] SAT_POS    = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG    = 32'h8000_0000;
    localparam int               MAG_W      = Q_W - FRAC_W;

    typedef struct packed {
        logic  neg;
        t_qval v;
    } t_qdiff;

    typedef struct packed {
        logic             clip;
        logic [OUT_W-1:0] v;
    } t_outv;

    // magnitude times small constant, overflow when it leaves 64 bits
    function automatic t_qval qscale(t_qval a, logic [4:0] k);
        logic [Q_W+4:0] p;
        t_qval          r;
        p = {5'b0, a.m} * {{Q_W{1'b0}}, k};
        r = '0;
        if (qzero(a)) begin
            r = '0;
        end else if (a.ovf || (p[Q_W+4:Q_W] != '0)) begin
            r.ovf = 1'b1;
        end else begin
            r.m = p[Q_W-1:0];
        end
        return r;
    endfunction

    // signed difference of two magnitudes; overflowed minuend wins as positive
    function automatic t_qdiff qsub(t_qval a, t_qval b);
        t_qdiff r;
        r = '0;
        if (a.ovf) begin
            r.v.ovf = 1'b1;
        end else if (b.ovf) begin
            r.v.ovf = 1'b1;
            r.neg   = 1'b1;
        end else if (a.m >= b.m) begin
            r.v.m = a.m - b.m;
        end else begin
            r.v.m = b.m - a.m;
            r.neg = 1'b1;
        end
        return r;
    endfunction

    // Q32.32 magnitude plus sign to saturated signed Q16.16
    function automatic t_outv to_out(t_qval a, logic neg);
        logic [MAG_W-1:0] mag;
        t_outv            r;
        mag = a.m[Q_W-1:FRAC_W];
        r   = '0;
        if (qzero(a)) begin
            r = '0;
        end else if (a.ovf) begin
            r.clip = 1'b1;
            r.v    = neg ? SAT_NEG : SAT_POS;
        end else if (!neg) begin
            if (mag > MAG_W'(SAT_POS)) begin
                r.clip = 1'b1;
                r.v    = SAT_POS;
            end else begin
                r.v = mag[OUT_W-1:0];
            end
        end else begin
            if (mag > MAG_W'(SAT_NEG)) begin
                r.clip = 1'b1;
                r.v    = SAT_NEG;
            end else begin
                r.v = OUT_W'(0) - mag[OUT_W-1:0];
            end
        end
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic [POS_W-1:0] r_well_depth;
    logic [POS_W-1:0] r_sigma_pow6;
    logic [CUT_W-1:0] r_cutoff_sq;
    logic [POS_W-1:0] r_inv_mass;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_depth <= RST_WELL_DEPTH;
            r_sigma_pow6 <= RST_SIGMA_POW6;
            r_cutoff_sq  <= RST_CUTOFF_SQ;
            r_inv_mass   <= RST_INV_MASS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_WELL_DEPTH: r_well_depth <= i_cfg.data[POS_W-1:0];
                REG_SIGMA_POW6: r_sigma_pow6 <= i_cfg.data[POS_W-1:0];
                REG_CUTOFF_SQ:  r_cutoff_sq  <= i_cfg.data[CUT_W-1:0];
                REG_INV_MASS:   r_inv_mass   <= i_cfg.data[POS_W-1:0];
                default: ;   // unknown index, write dropped
            endcase
        end
    end

    // register values as Q32.32 operands
    t_qval w_eps;
    t_qval w_sigma;
    t_qval w_imass;
    assign w_eps   = '{ovf: 1'b0, m: Q_W'({r_well_depth, {FRAC_W{1'b0}}})};
    assign w_sigma = '{ovf: 1'b0, m: Q_W'({r_sigma_pow6, {FRAC_W{1'b0}}})};
    assign w_imass = '{ovf: 1'b0, m: Q_W'({r_inv_mass, {FRAC_W{1'b0}}})};

    // ---------------- global advance ----------------
    // Everything moves together unless the skid register holds an item.
    logic w_en;
    logic r_sk_v;
    logic r_out_v;
    logic w_take;

    assign w_en         = !r_sk_v;
    assign i_pair.ready = w_en;
    assign w_take       = r_out_v && o_result.ready;

    // ---------------- front: deltas, squares, r2, gating ----------------
    logic             r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    logic             r_f1_idok, r_f2_idok, r_f3_idok;
    logic             r_f1_xneg, r_f1_yneg;
    logic [POS_W-1:0] r_f1_dxm, r_f1_dym;
    logic [SQ_W-1:0]  r_f2_sqx, r_f2_sqy;
    logic [R2_W-1:0]  r_f3_r2, r_f4_r2;
    t_side            r_f2_side, r_f3_side, r_f4_side;
    logic             w_xneg, w_yneg;
    t_side            n_f2_side, n_f4_side;

    assign w_xneg = i_pair.first_x < i_pair.second_x;
    assign w_yneg = i_pair.first_y < i_pair.second_y;

    always_comb begin
        n_f2_side      = '0;
        n_f2_side.xneg = r_f1_xneg;
        n_f2_side.yneg = r_f1_yneg;
        n_f2_side.dxm  = r_f1_dxm;
        n_f2_side.dym  = r_f1_dym;
    end

    always_comb begin
        n_f4_side        = r_f3_side;
        // pair unused if positions match, r2 exceeds cutoff or second_id <= first_id
        n_f4_side.used   = r_f3_idok && (r_f3_r2 != '0)
                         && (r_f3_r2 <= R2_W'({r_cutoff_sq, {FRAC_W{1'b0}}}));
        n_f4_side.r2_one = r_f3_r2 == R2_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_pair.valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_idok <= i_pair.second_id > i_pair.first_id;
            r_f1_xneg <= w_xneg;
            r_f1_yneg <= w_yneg;
            r_f1_dxm  <= w_xneg ? i_pair.second_x - i_pair.first_x
                                : i_pair.first_x - i_pair.second_x;
            r_f1_dym  <= w_yneg ? i_pair.second_y - i_pair.first_y
                                : i_pair.first_y - i_pair.second_y;
            r_f2_idok <= r_f1_idok;
            r_f2_sqx  <= r_f1_dxm * r_f1_dxm;
            r_f2_sqy  <= r_f1_dym * r_f1_dym;
            r_f2_side <= n_f2_side;
            r_f3_idok <= r_f2_idok;
            r_f3_r2   <= R2_W'(r_f2_sqx) + R2_W'(r_f2_sqy);
            r_f3_side <= r_f2_side;
            r_f4_r2   <= r_f3_r2;
            r_f4_side <= n_f4_side;
        end
    end

    // ---------------- reciprocal of r2 ----------------
    logic           w_dv_v;
    logic [Q_W-1:0] w_dv_q;
    t_side          w_dv_side;
    t_side          w_s1_side;

    ljpf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f4_v),
        .i_r2    (r_f4_r2),
        .i_side  (r_f4_side),
        .o_valid (w_dv_v),
        .o_quot  (w_dv_q),
        .o_side  (w_dv_side)
    );

    always_comb begin
        w_s1_side = w_dv_side;
        // r2 of one LSB gives 2^64, which no longer fits
        w_s1_side.inv.ovf = w_dv_side.r2_one;
        w_s1_side.inv.m   = w_dv_side.r2_one ? '0 : w_dv_q;
    end

    // ---------------- s6 = sigma6 / r2^3, s12 = s6^2 ----------------
    logic  w_m1_v, w_m2_v, w_m3_v, w_m4_v;
    t_qval w_m1_r, w_m2_r, w_m3_r, w_m4_r;
    t_side w_m1_side, w_m2_side, w_m3_side, w_m4_side;
    t_side w_s4_side;

    ljpf_qmul u_mul_s1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_dv_v), .i_a (w_sigma), .i_b (w_s1_side.inv), .i_side (w_s1_side),
        .o_valid (w_m1_v), .o_r (w_m1_r), .o_side (w_m1_side)
    );

    ljpf_qmul u_mul_s2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m1_v), .i_a (w_m1_r), .i_b (w_m1_side.inv), .i_side (w_m1_side),
        .o_valid (w_m2_v), .o_r (w_m2_r), .o_side (w_m2_side)
    );

    ljpf_qmul u_mul_s6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m2_v), .i_a (w_m2_r), .i_b (w_m2_side.inv), .i_side (w_m2_side),
        .o_valid (w_m3_v), .o_r (w_m3_r), .o_side (w_m3_side)
    );

    always_comb begin
        w_s4_side    = w_m3_side;
        w_s4_side.s6 = w_m3_r;
    end

    ljpf_qmul u_mul_s12 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m3_v), .i_a (w_m3_r), .i_b (w_m3_r), .i_side (w_s4_side),
        .o_valid (w_m4_v), .o_r (w_m4_r), .o_side (w_m4_side)
    );

    // ---------------- t = 2*s12 - s6, d = s12 - s6 ----------------
    logic   r_t_v;
    t_qval  r_t_t, r_t_d;
    t_side  r_t_side;
    t_qdiff w_tdiff, w_ddiff;
    t_side  n_t_side;

    assign w_tdiff = qsub(qscale(w_m4_r, SCALE_TWO), w_m4_side.s6);
    assign w_ddiff = qsub(w_m4_r, w_m4_side.s6);

    always_comb begin
        n_t_side      = w_m4_side;
        n_t_side.tneg = w_tdiff.neg;
        n_t_side.eneg = w_ddiff.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (w_en) begin
            r_t_v <= w_m4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_t    <= w_tdiff.v;
            r_t_d    <= w_ddiff.v;
            r_t_side <= n_t_side;
        end
    end

    // ---------------- eps*t and eps*d ----------------
    logic  w_m5_v;
    t_qval w_m5_r, w_m5e_r;
    t_side w_m5_side;

    ljpf_qmul u_mul_ft (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_t_v), .i_a (w_eps), .i_b (r_t_t), .i_side (r_t_side),
        .o_valid (w_m5_v), .o_r (w_m5_r), .o_side (w_m5_side)
    );

    ljpf_qmul u_mul_fe (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_t_v), .i_a (w_eps), .i_b (r_t_d), .i_side (r_t_side),
        .o_valid (), .o_r (w_m5e_r), .o_side ()
    );

    // ---------------- constant scales: 24 for force, 4 for energy ----------------
    logic  r_u_v;
    t_qval r_u_p24;
    t_side r_u_side;
    t_side n_u_side;

    always_comb begin
        n_u_side   = w_m5_side;
        n_u_side.e = qscale(w_m5e_r, SCALE_FOUR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (w_en) begin
            r_u_v <= w_m5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_p24  <= qscale(w_m5_r, SCALE_LJ);
            r_u_side <= n_u_side;
        end
    end

    // ---------------- f = 24*eps*t / r2, then per axis ----------------
    logic  w_m6_v, w_m7_v, w_m8_v;
    t_qval w_m6_r, w_m7x_r, w_m7y_r, w_m8x_r, w_m8y_r;
    t_side w_m6_side, w_m7_side, w_m8_side;
    t_qval w_dxq, w_dyq;

    ljpf_qmul u_mul_f (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_u_v), .i_a (r_u_p24), .i_b (r_u_side.inv), .i_side (r_u_side),
        .o_valid (w_m6_v), .o_r (w_m6_r), .o_side (w_m6_side)
    );

    assign w_dxq = '{ovf: 1'b0, m: Q_W'({w_m6_side.dxm, {FRAC_W{1'b0}}})};
    assign w_dyq = '{ovf: 1'b0, m: Q_W'({w_m6_side.dym, {FRAC_W{1'b0}}})};

    ljpf_qmul u_mul_fx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m6_v), .i_a (w_m6_r), .i_b (w_dxq), .i_side (w_m6_side),
        .o_valid (w_m7_v), .o_r (w_m7x_r), .o_side (w_m7_side)
    );

    ljpf_qmul u_mul_fy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m6_v), .i_a (w_m6_r), .i_b (w_dyq), .i_side (w_m6_side),
        .o_valid (), .o_r (w_m7y_r), .o_side ()
    );

    ljpf_qmul u_mul_ax (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m7_v), .i_a (w_m7x_r), .i_b (w_imass), .i_side (w_m7_side),
        .o_valid (w_m8_v), .o_r (w_m8x_r), .o_side (w_m8_side)
    );

    ljpf_qmul u_mul_ay (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_m7_v), .i_a (w_m7y_r), .i_b (w_imass), .i_side (w_m7_side),
        .o_valid (), .o_r (w_m8y_r), .o_side ()
    );

    // ---------------- saturate to Q16.16 ----------------
    logic    r_v_v;
    t_result r_v_res;
    t_outv   w_ox, w_oy, w_oe;
    t_result n_v_res;

    // accel sign: force sign times direction of (first - second)
    assign w_ox = to_out(w_m8x_r, w_m8_side.tneg != w_m8_side.xneg);
    assign w_oy = to_out(w_m8y_r, w_m8_side.tneg != w_m8_side.yneg);
    assign w_oe = to_out(w_m8_side.e, w_m8_side.eneg);

    always_comb begin
        n_v_res = '0;
        if (w_m8_side.used) begin
            n_v_res.pair_used   = 1'b1;
            n_v_res.accel_x     = w_ox.v;
            n_v_res.accel_y     = w_oy.v;
            n_v_res.pair_energy = w_oe.v;
            n_v_res.clipped     = w_ox.clip || w_oy.clip || w_oe.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_v <= 1'b0;
        end else if (w_en) begin
            r_v_v <= w_m8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v_res <= n_v_res;
        end
    end

    // ---------------- output register plus skid ----------------
    // Skid catches the item leaving the pipe while the output waits;
    // while it is full the pipe and the input hold.
    t_result r_out;
    t_result r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (w_take) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= r_v_v;
        end else if (r_v_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (w_take) begin
                r_out <= r_sk;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= r_v_res;
        end else begin
            r_sk <= r_v_res;
        end
    end

    assign o_result.valid       = r_out_v;
    assign o_result.pair_used   = r_out.pair_used;
    assign o_result.accel_x     = r_out.accel_x;
    assign o_result.accel_y     = r_out.accel_y;
    assign o_result.pair_energy = r_out.pair_energy;
    assign o_result.clipped     = r_out.clipped;

    // ---------------- checks ----------------
    logic w_out_unused;
    logic w_out_zero;
    logic w_out_clip;
    logic w_out_sat;

    assign w_out_unused = o_result.valid && !o_result.pair_used;
    assign w_out_zero   = (o_result.accel_x == '0) && (o_result.accel_y == '0)
                        && (o_result.pair_energy == '0) && !o_result.clipped;
    assign w_out_clip   = o_result.valid && o_result.clipped;
    assign w_out_sat    = (o_result.accel_x == SAT_POS) || (o_result.accel_x == SAT_NEG)
                        || (o_result.accel_y == SAT_POS) || (o_result.accel_y == SAT_NEG)
                        || (o_result.pair_energy == SAT_POS)
                        || (o_result.pair_energy == SAT_NEG);

    `LJPF_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_sk_v, r_out_v)
    `LJPF_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_sk_v && !w_take, r_sk_v)
    `LJPF_ASSERT_NOW(a_unused_zero, i_clk, i_rst_n, w_out_unused, w_out_zero)
    `LJPF_ASSERT_NOW(a_clip_saturated, i_clk, i_rst_n, w_out_clip, w_out_sat)

endmodule
